@@ design/vibration_pattern_sequencer_assert.svh @@
// Assertion macros for the vibration pattern sequencer.
`ifndef VIBRATION_PATTERN_SEQUENCER_ASSERT_SVH
`define VIBRATION_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define VPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vps assertion failed");

`else

`define VPS_ASSERT_SAME(label, clk, rst, ante, cons)
`define VPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/vps_pkg.sv @@
// Types, mode codes and drive levels shared by the sequencer files.
package vps_pkg;

  typedef struct packed {
    logic       func;
    logic       work_enable;
    logic       charging;
    logic [7:0] vib_mode;
    logic [7:0] suction_mode;
  } vps_item_t;

  typedef struct packed {
    logic       vib_on;
    logic [7:0] vib_level;
    logic       suction_on;
    logic [7:0] suction_level;
    logic       suction_clear_req;
  } vps_result_t;

  typedef struct packed {
    logic [15:0] tick_count;
    logic [7:0]  latched_vib_mode;
    logic [7:0]  latched_suction_mode;
    logic        vib_enable;
    logic [7:0]  vib_compare;
    logic        suction_enable;
    logic [7:0]  suction_compare;
  } vps_state_t;

  // Item kinds carried in func.
  localparam logic FUNC_EVAL = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Vibration mode codes.
  localparam logic [7:0] VIB_OFF    = 8'd0;
  localparam logic [7:0] VIB_FIXED1 = 8'd1;
  localparam logic [7:0] VIB_FIXED2 = 8'd2;
  localparam logic [7:0] VIB_FIXED3 = 8'd3;
  localparam logic [7:0] VIB_FIXED4 = 8'd4;
  localparam logic [7:0] VIB_BLINK  = 8'd5;
  localparam logic [7:0] VIB_BURST  = 8'd6;
  localparam logic [7:0] VIB_STEP   = 8'd7;

  // Suction mode codes.
  localparam logic [7:0] SUC_OFF  = 8'd0;
  localparam logic [7:0] SUC_LOW  = 8'd1;
  localparam logic [7:0] SUC_MID  = 8'd2;
  localparam logic [7:0] SUC_HIGH = 8'd3;

  // Drive levels.
  localparam logic [7:0] LEVEL_RESET = 8'd127;
  localparam logic [7:0] LEVEL_V1    = 8'd102;
  localparam logic [7:0] LEVEL_V2    = 8'd153;
  localparam logic [7:0] LEVEL_V3    = 8'd204;
  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_STEP1 = 8'd76;
  localparam logic [7:0] LEVEL_STEP2 = 8'd127;
  localparam logic [7:0] LEVEL_S1    = 8'd216;
  localparam logic [7:0] LEVEL_S2    = 8'd234;
  localparam logic [7:0] LEVEL_S3    = 8'd253;

  // Pattern timing in ticks.
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;
  localparam logic [15:0] BLINK_ON    = 16'd15;
  localparam logic [15:0] BLINK_END   = 16'd30;
  localparam logic [15:0] BURST_T0    = 16'd80;
  localparam logic [15:0] BURST_T1    = 16'd100;
  localparam logic [15:0] BURST_T2    = 16'd120;
  localparam logic [15:0] BURST_T3    = 16'd135;
  localparam logic [15:0] BURST_T4    = 16'd155;
  localparam logic [15:0] BURST_T5    = 16'd170;
  localparam logic [15:0] BURST_T6    = 16'd190;
  localparam logic [15:0] BURST_END   = 16'd205;
  localparam logic [15:0] STEP_T0     = 16'd100;
  localparam logic [15:0] STEP_T1     = 16'd200;
  localparam logic [15:0] STEP_END    = 16'd300;

  function automatic logic [7:0] vib_entry_level(input logic [7:0] mode);
    logic [7:0] lvl;
    case (mode)
      VIB_FIXED1: lvl = LEVEL_V1;
      VIB_FIXED2: lvl = LEVEL_V2;
      VIB_FIXED3: lvl = LEVEL_V3;
      VIB_STEP:   lvl = LEVEL_STEP1;
      default:    lvl = LEVEL_FULL;
    endcase
    return lvl;
  endfunction

  function automatic logic [7:0] suction_entry_level(input logic [7:0] mode);
    logic [7:0] lvl;
    case (mode)
      SUC_LOW: lvl = LEVEL_S1;
      SUC_MID: lvl = LEVEL_S2;
      default: lvl = LEVEL_S3;
    endcase
    return lvl;
  endfunction

endpackage

@@ design/vps_if.sv @@
// Handshake interfaces for the sequencer's input and result words.
interface vps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       work_enable;
  logic       charging;
  logic [7:0] vib_mode;
  logic [7:0] suction_mode;

  modport source (output valid, func, work_enable, charging, vib_mode, suction_mode,
                  input ready);
  modport sink (input valid, func, work_enable, charging, vib_mode, suction_mode,
                output ready);
endinterface

interface vps_out_if;
  logic       valid;
  logic       ready;
  logic       vib_on;
  logic [7:0] vib_level;
  logic       suction_on;
  logic [7:0] suction_level;
  logic       suction_clear_req;

  modport source (output valid, vib_on, vib_level, suction_on, suction_level,
                  suction_clear_req, input ready);
  modport sink (input valid, vib_on, vib_level, suction_on, suction_level,
                suction_clear_req, output ready);
endinterface

@@ design/vibration_pattern_sequencer.sv @@
// Top level of the two-motor vibration and suction drive sequencer.
//
//   Channel  Dir  Handshake      Word contents
//   req      in   valid/ready    func, work_enable, charging, vib_mode, suction_mode
//   rsp      out  valid/ready    vib_on, vib_level, suction_on, suction_level,
//                                suction_clear_req
//
// Every accepted word produces exactly one result word. It passes the input register
// and then the result register, and is handed on when the result side is free.
// A new word can be taken every cycle while rsp does not stall; the rate is set by the
// single evaluation stage between the input register and the result register.
// Reset (rst, synchronous) empties both registers and returns the drive state to
// motors off, levels 127, counter and latched modes zero.
// When rsp is stalled the word in the input register waits, and req.ready stays
// high only while that register is empty.
module vibration_pattern_sequencer import vps_pkg::*; (
  input logic    clk,
  input logic    rst,
  vps_in_if.sink   req,
  vps_out_if.source rsp
);

  `include "vibration_pattern_sequencer_assert.svh"

  // Input register.
  logic        stage_valid;
  vps_item_t   stage_item;

  // Drive state carried from word to word.
  vps_state_t  state;
  vps_state_t  state_next;

  // Result register.
  logic        out_valid;
  vps_result_t out_word;
  vps_result_t eval_res;

  logic advance;

  // The staged word moves on when the result register is empty or being emptied.
  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item.func         <= req.func;
      stage_item.work_enable  <= req.work_enable;
      stage_item.charging     <= req.charging;
      stage_item.vib_mode     <= req.vib_mode;
      stage_item.suction_mode <= req.suction_mode;
    end
  end

  vps_eval u_eval (
    .item (stage_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (eval_res)
  );

  // The drive state is committed only when the word's result is registered, so
  // words are applied strictly in order however the result side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.tick_count           <= 16'd0;
      state.latched_vib_mode     <= VIB_OFF;
      state.latched_suction_mode <= SUC_OFF;
      state.vib_enable           <= 1'b0;
      state.vib_compare          <= LEVEL_RESET;
      state.suction_enable       <= 1'b0;
      state.suction_compare      <= LEVEL_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= eval_res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.vib_on            = out_word.vib_on;
  assign rsp.vib_level         = out_word.vib_level;
  assign rsp.suction_on        = out_word.suction_on;
  assign rsp.suction_level     = out_word.suction_level;
  assign rsp.suction_clear_req = out_word.suction_clear_req;

  // A staged word that cannot move on is still there in the next cycle.
  `VPS_ASSERT_NEXT(a_stage_held, clk, rst, stage_valid && !advance, stage_valid)

  // An evaluate while disabled or charging always reports both motors off.
  `VPS_ASSERT_NEXT(a_disabled_off, clk, rst,
    advance && stage_item.func == FUNC_EVAL &&
    (!stage_item.work_enable || stage_item.charging),
    !rsp.vib_on && !rsp.suction_on && !rsp.suction_clear_req)

  // The tick counter saturates rather than wrapping.
  `VPS_ASSERT_NEXT(a_tick_saturates, clk, rst,
    advance && stage_item.func == FUNC_TICK && state.tick_count == TICK_MAX,
    state.tick_count == TICK_MAX)

  // With the result register empty the input side is never blocked.
  `VPS_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, req.ready)

endmodule

@@ design/vps_eval.sv @@
// Next-state and result logic for one tick or evaluate word.
module vps_eval import vps_pkg::*; (
  input  vps_item_t   item,
  input  vps_state_t  cur,
  output vps_state_t  nxt,
  output vps_result_t res
);

  logic clear_req;

  always_comb begin
    nxt       = cur;
    clear_req = 1'b0;
    if (item.func == FUNC_TICK) begin
      if (cur.tick_count != TICK_MAX) begin
        nxt.tick_count = cur.tick_count + 16'd1;
      end
    end else if (item.work_enable && !item.charging) begin
      // Vibration motor: a new mode is latched and loads its level.
      if (item.vib_mode == VIB_OFF) begin
        nxt.vib_enable = 1'b0;
      end else if (item.vib_mode <= VIB_STEP) begin
        if (cur.latched_vib_mode != item.vib_mode) begin
          nxt.latched_vib_mode = item.vib_mode;
          if (item.vib_mode != VIB_FIXED1) begin
            nxt.tick_count = 16'd0;
          end
          nxt.vib_compare = vib_entry_level(item.vib_mode);
          nxt.vib_enable  = 1'b1;
        end
      end

      // Timed patterns look at the counter after any restart above.
      case (item.vib_mode)
        VIB_BLINK: begin
          if (nxt.tick_count < BLINK_ON) nxt.vib_enable = 1'b1;
          else if (nxt.tick_count < BLINK_END) nxt.vib_enable = 1'b0;
          else nxt.tick_count = 16'd0;
        end
        VIB_BURST: begin
          if (nxt.tick_count < BURST_T0) nxt.vib_enable = 1'b1;
          else if (nxt.tick_count < BURST_T1) nxt.vib_enable = 1'b0;
          else if (nxt.tick_count < BURST_T2) nxt.vib_enable = 1'b1;
          else if (nxt.tick_count < BURST_T3) nxt.vib_enable = 1'b0;
          else if (nxt.tick_count < BURST_T4) nxt.vib_enable = 1'b1;
          else if (nxt.tick_count < BURST_T5) nxt.vib_enable = 1'b0;
          else if (nxt.tick_count < BURST_T6) nxt.vib_enable = 1'b1;
          else if (nxt.tick_count < BURST_END) nxt.vib_enable = 1'b0;
          else nxt.tick_count = 16'd0;
        end
        VIB_STEP: begin
          if (nxt.tick_count < STEP_T0) begin
            nxt.vib_compare = LEVEL_STEP1;
            nxt.vib_enable  = 1'b1;
          end else if (nxt.tick_count < STEP_T1) begin
            nxt.vib_compare = LEVEL_STEP2;
            nxt.vib_enable  = 1'b1;
          end else if (nxt.tick_count < STEP_END) begin
            nxt.vib_compare = LEVEL_FULL;
            nxt.vib_enable  = 1'b1;
          end else begin
            nxt.tick_count = 16'd0;
          end
        end
        default: begin
        end
      endcase

      // Suction motor.
      case (item.suction_mode)
        SUC_OFF: nxt.suction_enable = 1'b0;
        SUC_LOW, SUC_MID, SUC_HIGH: begin
          if (cur.latched_suction_mode != item.suction_mode) begin
            nxt.latched_suction_mode = item.suction_mode;
            nxt.suction_compare      = suction_entry_level(item.suction_mode);
            nxt.suction_enable       = 1'b1;
          end
        end
        default: clear_req = 1'b1;
      endcase
    end else begin
      nxt.vib_enable     = 1'b0;
      nxt.suction_enable = 1'b0;
    end
  end

  assign res.vib_on            = nxt.vib_enable;
  assign res.vib_level         = nxt.vib_compare;
  assign res.suction_on        = nxt.suction_enable;
  assign res.suction_level     = nxt.suction_compare;
  assign res.suction_clear_req = clear_req;

endmodule

@@ sim/tb_vibration_pattern_sequencer.sv @@
// Self-checking testbench for the vibration and suction drive sequencer.
module tb_vibration_pattern_sequencer;
  import vps_pkg::*;

  // The run is cut off here if the handshakes ever stop moving. The slowest
  // correct run sends about 1900 words. Each word waits out the longest gap
  // and the longest stall.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1800;
  localparam int MAX_GAP      = 18;
  // A result passes the input and result registers after its word is taken.
  // The drain allows a margin for stray words after the last expected one.
  localparam int DRAIN_CYCLES = 10;
  // From a count of twenty, this many more ticks carry the counter past the end
  // of the blink pattern.
  localparam int PAST_END_TICKS = 12;

  logic clk;
  logic rst;

  vps_in_if  req_bus ();
  vps_out_if rsp_bus ();

  vibration_pattern_sequencer dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // One row of the directed table. Where pinned is set, the result is typed in
  // by hand and replaces the prediction. Otherwise the predictor decides.
  typedef struct {
    vps_item_t   word;
    bit          pinned;
    vps_result_t result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  // Fields of a word in order: func, work_enable, charging, vib_mode, suction_mode.
  // Fields of a result in order: vib_on, vib_level, suction_on, suction_level,
  // suction_clear_req.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // A tick straight after reset shows the reset drive registers.
    '{'{FUNC_TICK, 1'b0, 1'b0, VIB_OFF, SUC_OFF}, 1'b1,
      '{1'b0, LEVEL_RESET, 1'b0, LEVEL_RESET, 1'b0}},
    // Disabled, and then charging: both motors are held off and nothing is latched.
    '{'{FUNC_EVAL, 1'b0, 1'b0, VIB_FIXED1, SUC_LOW}, 1'b1,
      '{1'b0, LEVEL_RESET, 1'b0, LEVEL_RESET, 1'b0}},
    '{'{FUNC_EVAL, 1'b1, 1'b1, VIB_STEP, SUC_HIGH}, 1'b1,
      '{1'b0, LEVEL_RESET, 1'b0, LEVEL_RESET, 1'b0}},
    // Entering the first fixed level and the low suction level.
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED1, SUC_LOW}, 1'b1,
      '{1'b1, LEVEL_V1, 1'b1, LEVEL_S1, 1'b0}},
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED1, SUC_LOW}, 1'b1,
      '{1'b1, LEVEL_V1, 1'b1, LEVEL_S1, 1'b0}},
    // Both modes off. The levels stay and the latches are left alone.
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_OFF, SUC_OFF}, 1'b1,
      '{1'b0, LEVEL_V1, 1'b0, LEVEL_S1, 1'b0}},
    // Asking again for the latched modes does not switch the motors back on.
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED1, SUC_LOW}, 1'b1,
      '{1'b0, LEVEL_V1, 1'b0, LEVEL_S1, 1'b0}},
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED2, SUC_MID}, 1'b1,
      '{1'b1, LEVEL_V2, 1'b1, LEVEL_S2, 1'b0}},
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED3, SUC_HIGH}, 1'b1,
      '{1'b1, LEVEL_V3, 1'b1, LEVEL_S3, 1'b0}},
    // Invalid suction modes raise the clear request and leave the suction side as it was.
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_FIXED4, 8'd255}, 1'b1,
      '{1'b1, LEVEL_FULL, 1'b1, LEVEL_S3, 1'b1}},
    // An invalid vibration mode leaves the vibration side as it was.
    '{'{FUNC_EVAL, 1'b1, 1'b0, 8'd255, 8'd4}, 1'b1,
      '{1'b1, LEVEL_FULL, 1'b1, LEVEL_S3, 1'b1}},
    '{'{FUNC_EVAL, 1'b1, 1'b0, 8'd8, SUC_OFF}, 1'b1,
      '{1'b1, LEVEL_FULL, 1'b0, LEVEL_S3, 1'b0}},
    // The three pattern modes, with ticks that carry junk in the unused fields.
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_BLINK, SUC_LOW}, 1'b0, '0},
    '{'{FUNC_TICK, 1'b1, 1'b1, 8'd255, 8'd255}, 1'b0, '0},
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_BURST, SUC_MID}, 1'b0, '0},
    '{'{FUNC_TICK, 1'b0, 1'b1, 8'd128, 8'd128}, 1'b0, '0},
    '{'{FUNC_EVAL, 1'b1, 1'b0, VIB_STEP, SUC_HIGH}, 1'b0, '0},
    // Charging turns both off while the step level stays at its first value.
    '{'{FUNC_EVAL, 1'b1, 1'b1, VIB_STEP, SUC_HIGH}, 1'b1,
      '{1'b0, LEVEL_STEP1, 1'b0, LEVEL_S3, 1'b0}},
    '{'{FUNC_EVAL, 1'b0, 1'b1, VIB_OFF, SUC_OFF}, 1'b0, '0},
    '{'{FUNC_TICK, 1'b0, 1'b0, VIB_OFF, SUC_OFF}, 1'b0, '0}
  };

  // Shadow of the block's drive state, kept in step by advance_drive.
  vps_state_t  drive_state;
  // Results still owed by the block, oldest first.
  vps_result_t pending_drive [$];

  // When set, neither side inserts gaps. This gives stretches at full rate.
  bit no_gaps;
  int cycle_count;
  int words_sent;
  int ticks_sent;
  int results_checked;
  int drive_mismatches;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void reset_drive();
    drive_state.tick_count           = '0;
    drive_state.latched_vib_mode     = VIB_OFF;
    drive_state.latched_suction_mode = SUC_OFF;
    drive_state.vib_enable           = 1'b0;
    drive_state.vib_compare          = LEVEL_RESET;
    drive_state.suction_enable       = 1'b0;
    drive_state.suction_compare      = LEVEL_RESET;
  endfunction

  // A mode only takes effect when it differs from the latched one. It then
  // loads its level and switches the motor on. The pattern modes and the
  // upper fixed levels also restart the tick counter.
  function automatic void enter_vib_mode(input logic [7:0] mode, input logic [7:0] lvl,
                                         input bit restart);
    if (drive_state.latched_vib_mode != mode) begin
      drive_state.latched_vib_mode = mode;
      if (restart) drive_state.tick_count = '0;
      drive_state.vib_compare = lvl;
      drive_state.vib_enable  = 1'b1;
    end
  endfunction

  function automatic void enter_suction_mode(input logic [7:0] mode, input logic [7:0] lvl);
    if (drive_state.latched_suction_mode != mode) begin
      drive_state.latched_suction_mode = mode;
      drive_state.suction_compare      = lvl;
      drive_state.suction_enable       = 1'b1;
    end
  endfunction

  // Applies one accepted word to the shadow state and returns the result word
  // that the block must produce for it.
  function automatic vps_result_t advance_drive(input vps_item_t w);
    logic        clear_req;
    logic [15:0] t;
    clear_req = 1'b0;
    if (w.func == FUNC_TICK) begin
      if (drive_state.tick_count != TICK_MAX) drive_state.tick_count += 16'd1;
    end else if (w.work_enable && !w.charging) begin
      case (w.vib_mode)
        VIB_OFF:    drive_state.vib_enable = 1'b0;
        VIB_FIXED1: enter_vib_mode(VIB_FIXED1, LEVEL_V1, 1'b0);
        VIB_FIXED2: enter_vib_mode(VIB_FIXED2, LEVEL_V2, 1'b1);
        VIB_FIXED3: enter_vib_mode(VIB_FIXED3, LEVEL_V3, 1'b1);
        VIB_FIXED4: enter_vib_mode(VIB_FIXED4, LEVEL_FULL, 1'b1);
        VIB_BLINK: begin
          enter_vib_mode(VIB_BLINK, LEVEL_FULL, 1'b1);
          t = drive_state.tick_count;
          if (t < BLINK_ON) drive_state.vib_enable = 1'b1;
          else if (t < BLINK_END) drive_state.vib_enable = 1'b0;
          else drive_state.tick_count = '0;
        end
        VIB_BURST: begin
          enter_vib_mode(VIB_BURST, LEVEL_FULL, 1'b1);
          t = drive_state.tick_count;
          // The burst alternates on and off windows. Past the last window the
          // counter restarts and the output is left as it stands.
          if (t >= BURST_END) begin
            drive_state.tick_count = '0;
          end else begin
            drive_state.vib_enable = (t < BURST_T0) ||
                                     (t >= BURST_T1 && t < BURST_T2) ||
                                     (t >= BURST_T3 && t < BURST_T4) ||
                                     (t >= BURST_T5 && t < BURST_T6);
          end
        end
        VIB_STEP: begin
          enter_vib_mode(VIB_STEP, LEVEL_STEP1, 1'b1);
          t = drive_state.tick_count;
          if (t < STEP_T0) begin
            drive_state.vib_compare = LEVEL_STEP1;
            drive_state.vib_enable  = 1'b1;
          end else if (t < STEP_T1) begin
            drive_state.vib_compare = LEVEL_STEP2;
            drive_state.vib_enable  = 1'b1;
          end else if (t < STEP_END) begin
            drive_state.vib_compare = LEVEL_FULL;
            drive_state.vib_enable  = 1'b1;
          end else begin
            drive_state.tick_count = '0;
          end
        end
        default: ;
      endcase
      case (w.suction_mode)
        SUC_OFF:  drive_state.suction_enable = 1'b0;
        SUC_LOW:  enter_suction_mode(SUC_LOW, LEVEL_S1);
        SUC_MID:  enter_suction_mode(SUC_MID, LEVEL_S2);
        SUC_HIGH: enter_suction_mode(SUC_HIGH, LEVEL_S3);
        default:  clear_req = 1'b1;
      endcase
    end else begin
      drive_state.vib_enable     = 1'b0;
      drive_state.suction_enable = 1'b0;
    end
    return '{drive_state.vib_enable, drive_state.vib_compare, drive_state.suction_enable,
             drive_state.suction_compare, clear_req};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // The number of idle cycles before a word or before taking a result. Zero
  // comes up often, so that back-to-back words are common even outside the
  // full-rate stretches.
  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic vps_item_t make_word(input logic func, input logic we, input logic chg,
                                          input logic [7:0] vm, input logic [7:0] sm);
    vps_item_t w;
    w.func         = func;
    w.work_enable  = we;
    w.charging     = chg;
    w.vib_mode     = vm;
    w.suction_mode = sm;
    return w;
  endfunction

  // Offers one word after a random gap and holds it until it is taken. The
  // expected result is queued at the edge where the word is accepted. Valid is
  // only lowered when a gap follows, so that a back-to-back word never sees two
  // assignments to valid in one step.
  task automatic send_word(input vps_item_t w, input bit pinned, input vps_result_t fixed_res);
    int          gap;
    vps_result_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.func         <= w.func;
    req_bus.work_enable  <= w.work_enable;
    req_bus.charging     <= w.charging;
    req_bus.vib_mode     <= w.vib_mode;
    req_bus.suction_mode <= w.suction_mode;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = advance_drive(w);
    pending_drive.push_back(pinned ? fixed_res : predicted);
    words_sent++;
    if (w.func == FUNC_TICK) ticks_sent++;
  endtask

  // A random word within a segment. Most words are ticks, so that the counter
  // climbs far enough to reach every window of the three patterns. Most
  // evaluations ask for the segment's own modes, so the pattern stays latched
  // while the ticks accumulate. The remainder is noise over the full field ranges.
  function automatic vps_item_t random_word(input logic [7:0] seg_vib,
                                            input logic [7:0] seg_suc);
    vps_item_t w;
    int        roll;
    w = make_word(FUNC_TICK, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < 80) return w;
    w.func        = FUNC_EVAL;
    w.work_enable = ($urandom_range(0, 9) != 0);
    w.charging    = ($urandom_range(0, 9) == 0);
    roll = $urandom_range(0, 9);
    if (roll < 8) w.vib_mode = seg_vib;
    else if (roll == 8) w.vib_mode = 8'($urandom_range(VIB_OFF, VIB_STEP));
    roll = $urandom_range(0, 19);
    if (roll < 15) w.suction_mode = seg_suc;
    else if (roll < 18) w.suction_mode = 8'($urandom_range(SUC_OFF, SUC_HIGH));
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_drive.size());
      $display("vibration_pattern_sequencer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // --------------------------------------------------------------------------

  // Ready is held low for a freshly drawn stall before each result word, then
  // held high until that word is taken.
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
    end
  end

  // Every accepted result word is compared field by field with the oldest
  // expectation. Only the first few failures are described in full.
  always @(posedge clk) begin
    vps_result_t got;
    vps_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = '{rsp_bus.vib_on, rsp_bus.vib_level, rsp_bus.suction_on, rsp_bus.suction_level,
              rsp_bus.suction_clear_req};
      if (pending_drive.size() == 0) begin
        drive_mismatches++;
        if (drive_mismatches <= 10)
          $display("Unexpected result word vib %0b/%0d suction %0b/%0d clear %0b",
                   got.vib_on, got.vib_level, got.suction_on, got.suction_level,
                   got.suction_clear_req);
      end else begin
        want = pending_drive.pop_front();
        results_checked++;
        if (got.vib_on !== want.vib_on || got.vib_level !== want.vib_level ||
            got.suction_on !== want.suction_on || got.suction_level !== want.suction_level ||
            got.suction_clear_req !== want.suction_clear_req) begin
          drive_mismatches++;
          if (drive_mismatches <= 10)
            $display("Result %0d: expected vib %0b/%0d suction %0b/%0d clear %0b, %s",
                     results_checked, want.vib_on, want.vib_level, want.suction_on,
                     want.suction_level, want.suction_clear_req,
                     $sformatf("got vib %0b/%0d suction %0b/%0d clear %0b", got.vib_on,
                               got.vib_level, got.suction_on, got.suction_level,
                               got.suction_clear_req));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int          seg_len;
    int          random_sent;
    logic [7:0]  seg_vib;
    logic [7:0]  seg_suc;
    vps_result_t unused_res;

    unused_res       = '0;
    no_gaps          = 1'b0;
    cycle_count      = 0;
    words_sent       = 0;
    ticks_sent       = 0;
    results_checked  = 0;
    drive_mismatches = 0;
    random_sent      = 0;
    reset_drive();

    // Every input is at a known value from time zero onwards.
    rst                  = 1'b1;
    req_bus.valid        = 1'b0;
    req_bus.func         = FUNC_EVAL;
    req_bus.work_enable  = 1'b0;
    req_bus.charging     = 1'b0;
    req_bus.vib_mode     = VIB_OFF;
    req_bus.suction_mode = SUC_OFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].result);

    // Pattern end, at full rate on both sides. The blink is latched and moved
    // into its off half. The counter is then driven past the pattern. The next
    // evaluation restarts it and leaves the motor off. The evaluation after
    // that is back in the on half.
    no_gaps = 1'b1;
    send_word(make_word(FUNC_EVAL, 1'b1, 1'b0, VIB_BLINK, SUC_MID), 1'b0, unused_res);
    repeat (20) send_word(make_word(FUNC_TICK, 1'b0, 1'b0, VIB_OFF, SUC_OFF), 1'b0, unused_res);
    send_word(make_word(FUNC_EVAL, 1'b1, 1'b0, VIB_BLINK, SUC_MID), 1'b0, unused_res);
    repeat (PAST_END_TICKS)
      send_word(make_word(FUNC_TICK, 1'b0, 1'b0, VIB_OFF, SUC_OFF), 1'b0, unused_res);
    repeat (2) send_word(make_word(FUNC_EVAL, 1'b1, 1'b0, VIB_BLINK, SUC_MID), 1'b0, unused_res);

    // Random part, in segments. Each segment settles on a vibration mode and a
    // suction mode. The pattern modes are chosen most often. Roughly one
    // segment in four runs without gaps on either side.
    while (random_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) seg_vib = 8'($urandom_range(VIB_BLINK, VIB_STEP));
      else seg_vib = 8'($urandom_range(VIB_OFF, VIB_FIXED4));
      seg_suc = 8'($urandom_range(SUC_OFF, SUC_HIGH));
      seg_len = $urandom_range(20, 450);
      if (seg_len > RANDOM_WORDS - random_sent) seg_len = RANDOM_WORDS - random_sent;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        send_word(random_word(seg_vib, seg_suc), 1'b0, unused_res);
        random_sent++;
      end
    end

    // Drain: wait for every owed result, then watch a little longer for strays.
    req_bus.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d ticks, %0d evaluations), with the blink run %s",
             words_sent, ticks_sent, words_sent - ticks_sent, "past its end once.");
    $display("Checked %0d result words; %0d mismatched, %0d still owed.",
             results_checked, drive_mismatches, pending_drive.size());
    if (drive_mismatches == 0 && pending_drive.size() == 0) begin
      $display("vibration_pattern_sequencer: match");
    end else begin
      $display("vibration_pattern_sequencer: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/vps_pkg.sv
design/vps_if.sv
design/vps_eval.sv
design/vibration_pattern_sequencer.sv
sim/tb_vibration_pattern_sequencer.sv
